// File: sv/lvra_pkg.sv
// Shared types, constants and controller/datapath interface structs for the voxel averager.
package lvra_pkg;

  localparam int RES_W          = 48;
  localparam int DEPTH_W        = 32;
  localparam int FRAC_W         = 31;
  localparam int DIV_W          = 64;
  localparam int DIV_CNT_W      = 7;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 6;
  localparam int DEF_MAX_LAYERS = 32;

  localparam logic [RES_W-1:0]  RES_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam logic [FRAC_W-1:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [FRAC_W-1:0] FRAC_TOL  = 31'd107374;
  localparam logic [DIV_W-1:0]  HARM_NUM  = 64'h8000_0000_0000_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'b1;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SUM  = 2'd1;
  localparam logic [1:0] STAT_NONE = 2'd2;

  typedef enum logic [1:0] {
    FUNC_LOAD_RES   = 2'd0,
    FUNC_LOAD_IFACE = 2'd1,
    FUNC_EVAL       = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    DIV_FRAC,
    DIV_CX,
    DIV_CY,
    DIV_HX,
    DIV_HY
  } div_sel_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_READ,
    S_CLIP,
    S_CHK,
    S_FRAC,
    S_FRAC_W,
    S_CX,
    S_CX_W,
    S_CY,
    S_CY_W,
    S_MZA,
    S_MZB,
    S_MZC,
    S_NEXT,
    S_HX,
    S_HX_W,
    S_HY,
    S_HY_W,
    S_OUT
  } state_t;

  typedef struct packed {
    logic     wr_res;
    logic     wr_if;
    logic     load_eval;
    logic     rd;
    logic     clip;
    logic     div_start;
    div_sel_t div_sel;
    logic     lat_frac;
    logic     lat_cx;
    logic     set_zx;
    logic     lat_cy;
    logic     set_zy;
    logic     mul_a;
    logic     mul_b;
    logic     acc_z;
    logic     next_layer;
    logic     lat_hx;
    logic     lat_hy;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic thick_pos;
    logic rho_x_zero;
    logic rho_y_zero;
    logic last;
    logic div_done;
    logic hx_direct;
    logic hy_direct;
    logic mode;
    logic out_free;
  } dp_stat_t;

endpackage

// File: sv/layered_voxel_resistivity_average.sv
// Top level of the layered voxel resistivity averager: controller plus datapath.
//
// The input channel (in_valid / in_stall) carries one item per handshake. A load item
// (func 0 or 1) writes one layer's resistivities or one interface depth and is done in
// the cycle it is taken; it gives no result. An evaluate item (func 2) walks every layer
// in use, clips its span to the voxel and averages the resistivities; it gives exactly
// one result item on the output channel (out_valid / out_stall). Any other func code is
// taken and dropped.
// After the accepting cycle an evaluate item reads and clips each layer in turn. An
// overlapping layer takes a fraction division and an x conductance division in isotropic
// mode, and in anisotropic mode also a y conductance division and the z product. Each
// harmonic result then takes a division unless it can be set directly, and then the
// result is written. The single shared 64-bit divider, one quotient bit a cycle, does
// every division. A zero resistivity skips its conductance division. While an item is
// at work in_stall stays high.
// The result waits in an output register; a new item is taken while it waits, and the
// next result is written only once the receiver has taken the old one.
// Reset clears the controller, the output valid flag and the two configuration
// registers (isotropic mode, one layer). The tables hold nothing defined until loaded.
module layered_voxel_resistivity_average #(
  parameter int MAX_LAYERS = lvra_pkg::DEF_MAX_LAYERS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          func,
  input  logic [4:0]                          slot,
  input  logic [lvra_pkg::RES_W-1:0]          res_x,
  input  logic [lvra_pkg::RES_W-1:0]          res_y,
  input  logic [lvra_pkg::RES_W-1:0]          res_z,
  input  logic signed [lvra_pkg::DEPTH_W-1:0] iface_depth,
  input  logic signed [lvra_pkg::DEPTH_W-1:0] voxel_top,
  input  logic signed [lvra_pkg::DEPTH_W-1:0] voxel_bottom,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lvra_pkg::RES_W-1:0]          out_res_x,
  output logic [lvra_pkg::RES_W-1:0]          out_res_y,
  output logic [lvra_pkg::RES_W-1:0]          out_res_z,
  output logic [1:0]                          status,
  input  logic                                cfg_we,
  input  logic [lvra_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lvra_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Commands flow from the controller to the datapath, status flows back.
  lvra_pkg::ctrl_cmd_t cmd;
  lvra_pkg::dp_stat_t  stat;

  lvra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .stat     (stat),
    .cmd      (cmd)
  );

  lvra_dp #(
    .MAX_LAYERS (MAX_LAYERS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .slot         (slot),
    .res_x        (res_x),
    .res_y        (res_y),
    .res_z        (res_z),
    .iface_depth  (iface_depth),
    .voxel_top    (voxel_top),
    .voxel_bottom (voxel_bottom),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_res_x    (out_res_x),
    .out_res_y    (out_res_y),
    .out_res_z    (out_res_z),
    .status       (status)
  );

`ifndef SYNTHESIS
  // Once an evaluate item is taken, the block must be busy in the next cycle.
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && func == lvra_pkg::FUNC_EVAL |=> in_stall)
    else $error("evaluate item accepted but block not busy");

  // A voxel with no overlap must give all-zero resistivities.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == lvra_pkg::STAT_NONE |->
      out_res_x == '0 && out_res_y == '0 && out_res_z == '0)
    else $error("no-overlap result carries non-zero resistivity");

  // In isotropic mode the y and z results are zero.
  a_iso_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !stat.mode |-> out_res_y == '0 && out_res_z == '0)
    else $error("isotropic result carries y or z resistivity");

  // The output register is only written when it is free.
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid || !out_stall)
    else $error("result written over a waiting result");
`endif

endmodule

// File: sv/lvra_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions of the averager.
module lvra_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lvra_pkg::DIV_W-1:0]   dividend,
  input  logic [lvra_pkg::DIV_W-1:0]   divisor,
  output logic                         done,
  output logic [lvra_pkg::DIV_W-1:0]   quotient
);

  logic                            run;
  logic [lvra_pkg::DIV_CNT_W-1:0]  cnt;
  logic [lvra_pkg::DIV_W-1:0]      rem;
  logic [lvra_pkg::DIV_W-1:0]      dvd;
  logic [lvra_pkg::DIV_W-1:0]      dvs;
  logic [lvra_pkg::DIV_W:0]        trial;
  logic                            ge;

  assign trial = {rem, dvd[lvra_pkg::DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= lvra_pkg::DIV_CNT_W'(lvra_pkg::DIV_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == lvra_pkg::DIV_CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (run) begin
      dvd      <= {dvd[lvra_pkg::DIV_W-2:0], 1'b0};
      quotient <= {quotient[lvra_pkg::DIV_W-2:0], ge};
      if (ge) begin
        rem <= lvra_pkg::DIV_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[lvra_pkg::DIV_W-1:0];
      end
    end
  end

endmodule

// File: sv/lvra_dp.sv
// Datapath: tables, configuration registers, clipping, accumulators and the result register.
module lvra_dp #(
  parameter int MAX_LAYERS = lvra_pkg::DEF_MAX_LAYERS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lvra_pkg::ctrl_cmd_t                 cmd,
  output lvra_pkg::dp_stat_t                  stat,
  input  logic                                cfg_we,
  input  logic [lvra_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lvra_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [4:0]                          slot,
  input  logic [lvra_pkg::RES_W-1:0]          res_x,
  input  logic [lvra_pkg::RES_W-1:0]          res_y,
  input  logic [lvra_pkg::RES_W-1:0]          res_z,
  input  logic signed [lvra_pkg::DEPTH_W-1:0] iface_depth,
  input  logic signed [lvra_pkg::DEPTH_W-1:0] voxel_top,
  input  logic signed [lvra_pkg::DEPTH_W-1:0] voxel_bottom,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lvra_pkg::RES_W-1:0]          out_res_x,
  output logic [lvra_pkg::RES_W-1:0]          out_res_y,
  output logic [lvra_pkg::RES_W-1:0]          out_res_z,
  output logic [1:0]                          status
);

  localparam int LW    = $clog2(MAX_LAYERS);
  localparam int CW    = $clog2(MAX_LAYERS + 1);
  localparam int SUM_W = lvra_pkg::FRAC_W + CW;
  localparam int AZ_W  = lvra_pkg::RES_W + CW;
  localparam int RW    = lvra_pkg::RES_W;
  localparam int DW    = lvra_pkg::DEPTH_W;

  logic [RW-1:0] mem_x [MAX_LAYERS];
  logic [RW-1:0] mem_y [MAX_LAYERS];
  logic [RW-1:0] mem_z [MAX_LAYERS];
  logic [DW-1:0] mem_if [MAX_LAYERS];

  logic          mode;
  logic [5:0]    layer_count;

  logic signed [DW-1:0] top;
  logic signed [DW-1:0] bot;
  logic [DW:0]          dz;
  logic [CW-1:0]        n;
  logic [LW-1:0]        l;

  logic signed [DW-1:0] if_up;
  logic signed [DW-1:0] if_dn;
  logic [RW-1:0]        rx;
  logic [RW-1:0]        ry;
  logic [RW-1:0]        rz;

  logic [DW:0]          thick;
  logic                 thick_pos;
  logic [lvra_pkg::FRAC_W-1:0] frac;
  logic [SUM_W-1:0]     sum;
  logic                 any;
  logic [lvra_pkg::DIV_W-1:0] gx;
  logic [lvra_pkg::DIV_W-1:0] gy;
  logic                 zx;
  logic                 zy;
  logic [AZ_W-1:0]      az;
  logic [54:0]          pa;
  logic [54:0]          pb;
  logic [RW-1:0]        hx;
  logic [RW-1:0]        hy;

  logic [6:0]           slot7;
  logic [7:0]           lc8;
  logic [7:0]           nc8;
  logic [LW-1:0]        l_m1;
  logic signed [DW+1:0] lo;
  logic signed [DW+1:0] hi;
  logic signed [DW+1:0] th;
  logic [78:0]          zsum;
  logic [SUM_W-1:0]     diff;
  logic [lvra_pkg::DIV_W:0] gx_add;
  logic [lvra_pkg::DIV_W:0] gy_add;

  logic                        div_done;
  logic [lvra_pkg::DIV_W-1:0]  div_q;
  logic [lvra_pkg::DIV_W-1:0]  div_a;
  logic [lvra_pkg::DIV_W-1:0]  div_b;

  function automatic logic [lvra_pkg::RES_W-1:0] harm(
    input logic                        zf,
    input logic [lvra_pkg::DIV_W-1:0]  g,
    input logic [lvra_pkg::DIV_W-1:0]  q
  );
    logic [lvra_pkg::RES_W-1:0] r;
    if (zf) begin
      r = '0;
    end else if (g == '0 || q[lvra_pkg::DIV_W-1:lvra_pkg::RES_W] != '0) begin
      r = lvra_pkg::RES_MAX;
    end else begin
      r = q[lvra_pkg::RES_W-1:0];
    end
    return r;
  endfunction

  assign slot7 = {2'b00, slot};
  assign lc8   = {2'b00, layer_count};
  assign l_m1  = l - LW'(1);

  always_comb begin
    if (lc8 == 8'd0) begin
      nc8 = 8'd1;
    end else if (lc8 > 8'(MAX_LAYERS)) begin
      nc8 = 8'(MAX_LAYERS);
    end else begin
      nc8 = lc8;
    end
  end

  // Clip the layer span to the voxel.
  always_comb begin
    lo = (DW+2)'(top);
    hi = (DW+2)'(bot);
    if (l != '0 && if_up > top) begin
      lo = (DW+2)'(if_up);
    end
    if (!stat.last && if_dn < bot) begin
      hi = (DW+2)'(if_dn);
    end
    th = hi - lo;
  end

  always_comb begin
    case (cmd.div_sel)
      lvra_pkg::DIV_FRAC: begin
        div_a = {1'b0, thick, 30'd0};
        div_b = {31'd0, dz};
      end
      lvra_pkg::DIV_CX: begin
        div_a = {frac, 33'd0};
        div_b = {16'd0, rx};
      end
      lvra_pkg::DIV_CY: begin
        div_a = {frac, 33'd0};
        div_b = {16'd0, ry};
      end
      lvra_pkg::DIV_HX: begin
        div_a = lvra_pkg::HARM_NUM;
        div_b = gx;
      end
      lvra_pkg::DIV_HY: begin
        div_a = lvra_pkg::HARM_NUM;
        div_b = gy;
      end
      default: begin
        div_a = '0;
        div_b = '0;
      end
    endcase
  end

  lvra_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  assign zsum   = {pa, 24'd0} + {24'd0, pb};
  assign gx_add = {1'b0, gx} + {1'b0, div_q};
  assign gy_add = {1'b0, gy} + {1'b0, div_q};

  always_comb begin
    if (sum > SUM_W'(lvra_pkg::ONE_Q30)) begin
      diff = sum - SUM_W'(lvra_pkg::ONE_Q30);
    end else begin
      diff = SUM_W'(lvra_pkg::ONE_Q30) - sum;
    end
  end

  always_comb begin
    stat.thick_pos  = thick_pos;
    stat.rho_x_zero = rx == '0;
    stat.rho_y_zero = ry == '0;
    stat.last       = (CW'(l) + CW'(1)) == n;
    stat.div_done   = div_done;
    stat.hx_direct  = zx || gx == '0;
    stat.hy_direct  = zy || gy == '0;
    stat.mode       = mode;
    stat.out_free   = !out_valid || !out_stall;
  end

  // Tables: written from the input item, read once per layer.
  always_ff @(posedge clk) begin
    if (cmd.wr_res && slot7 < 7'(MAX_LAYERS)) begin
      mem_x[slot7[LW-1:0]] <= res_x;
      mem_y[slot7[LW-1:0]] <= res_y;
      mem_z[slot7[LW-1:0]] <= res_z;
    end
    if (cmd.wr_if && slot7 < 7'(MAX_LAYERS - 1)) begin
      mem_if[slot7[LW-1:0]] <= iface_depth;
    end
    if (cmd.rd) begin
      if_up <= mem_if[l_m1];
      if_dn <= mem_if[l];
      rx    <= mem_x[l];
      ry    <= mem_y[l];
      rz    <= mem_z[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= 1'b0;
      layer_count <= 6'd1;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == lvra_pkg::CFG_MODE) begin
        mode <= cfg_data[0];
      end
      if (cfg_we && cfg_index == lvra_pkg::CFG_COUNT) begin
        layer_count <= cfg_data;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_eval) begin
      top <= voxel_top;
      bot <= voxel_bottom;
      dz  <= {voxel_bottom[DW-1], voxel_bottom} - {voxel_top[DW-1], voxel_top};
      n   <= nc8[CW-1:0];
      l   <= '0;
      sum <= '0;
      any <= 1'b0;
      gx  <= '0;
      gy  <= '0;
      zx  <= 1'b0;
      zy  <= 1'b0;
      az  <= '0;
    end
    if (cmd.clip) begin
      thick     <= th[DW:0];
      thick_pos <= !th[DW+1] && th != '0;
    end
    if (cmd.lat_frac) begin
      frac <= div_q[lvra_pkg::FRAC_W-1:0];
      sum  <= sum + SUM_W'(div_q[lvra_pkg::FRAC_W-1:0]);
      any  <= 1'b1;
    end
    if (cmd.lat_cx) begin
      gx <= gx_add[lvra_pkg::DIV_W] ? '1 : gx_add[lvra_pkg::DIV_W-1:0];
    end
    if (cmd.set_zx) begin
      zx <= 1'b1;
    end
    if (cmd.lat_cy) begin
      gy <= gy_add[lvra_pkg::DIV_W] ? '1 : gy_add[lvra_pkg::DIV_W-1:0];
    end
    if (cmd.set_zy) begin
      zy <= 1'b1;
    end
    if (cmd.mul_a) begin
      pa <= {24'd0, frac} * {31'd0, rz[47:24]};
    end
    if (cmd.mul_b) begin
      pb <= {24'd0, frac} * {31'd0, rz[23:0]};
    end
    if (cmd.acc_z) begin
      az <= az + AZ_W'(zsum[77:30]);
    end
    if (cmd.next_layer) begin
      l <= l + LW'(1);
    end
    if (cmd.lat_hx) begin
      hx <= harm(zx, gx, div_q);
    end
    if (cmd.lat_hy) begin
      hy <= harm(zy, gy, div_q);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (!any) begin
        out_res_x <= '0;
        out_res_y <= '0;
        out_res_z <= '0;
        status    <= lvra_pkg::STAT_NONE;
      end else begin
        out_res_x <= hx;
        out_res_y <= mode ? hy : '0;
        if (!mode) begin
          out_res_z <= '0;
        end else if (az > AZ_W'(lvra_pkg::RES_MAX)) begin
          out_res_z <= lvra_pkg::RES_MAX;
        end else begin
          out_res_z <= az[RW-1:0];
        end
        status <= (diff > SUM_W'(lvra_pkg::FRAC_TOL)) ? lvra_pkg::STAT_SUM : lvra_pkg::STAT_OK;
      end
    end
  end

endmodule

// File: sv/lvra_ctrl.sv
// Controller: sequences loads, the per-layer walk, the shared divider and the result hand-off.
module lvra_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           func,
  input  lvra_pkg::dp_stat_t   stat,
  output lvra_pkg::ctrl_cmd_t  cmd
);

  lvra_pkg::state_t state;
  lvra_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lvra_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lvra_pkg::S_IDLE: begin
        if (in_valid && func == lvra_pkg::FUNC_EVAL) begin
          state_next = lvra_pkg::S_READ;
        end
      end
      lvra_pkg::S_READ:  state_next = lvra_pkg::S_CLIP;
      lvra_pkg::S_CLIP:  state_next = lvra_pkg::S_CHK;
      lvra_pkg::S_CHK: begin
        state_next = stat.thick_pos ? lvra_pkg::S_FRAC : lvra_pkg::S_NEXT;
      end
      lvra_pkg::S_FRAC:  state_next = lvra_pkg::S_FRAC_W;
      lvra_pkg::S_FRAC_W: begin
        if (stat.div_done) begin
          state_next = lvra_pkg::S_CX;
        end
      end
      lvra_pkg::S_CX: begin
        if (!stat.rho_x_zero) begin
          state_next = lvra_pkg::S_CX_W;
        end else begin
          state_next = stat.mode ? lvra_pkg::S_CY : lvra_pkg::S_NEXT;
        end
      end
      lvra_pkg::S_CX_W: begin
        if (stat.div_done) begin
          state_next = stat.mode ? lvra_pkg::S_CY : lvra_pkg::S_NEXT;
        end
      end
      lvra_pkg::S_CY: begin
        state_next = stat.rho_y_zero ? lvra_pkg::S_MZA : lvra_pkg::S_CY_W;
      end
      lvra_pkg::S_CY_W: begin
        if (stat.div_done) begin
          state_next = lvra_pkg::S_MZA;
        end
      end
      lvra_pkg::S_MZA:   state_next = lvra_pkg::S_MZB;
      lvra_pkg::S_MZB:   state_next = lvra_pkg::S_MZC;
      lvra_pkg::S_MZC:   state_next = lvra_pkg::S_NEXT;
      lvra_pkg::S_NEXT: begin
        state_next = stat.last ? lvra_pkg::S_HX : lvra_pkg::S_READ;
      end
      lvra_pkg::S_HX: begin
        if (!stat.hx_direct) begin
          state_next = lvra_pkg::S_HX_W;
        end else begin
          state_next = stat.mode ? lvra_pkg::S_HY : lvra_pkg::S_OUT;
        end
      end
      lvra_pkg::S_HX_W: begin
        if (stat.div_done) begin
          state_next = stat.mode ? lvra_pkg::S_HY : lvra_pkg::S_OUT;
        end
      end
      lvra_pkg::S_HY: begin
        state_next = stat.hy_direct ? lvra_pkg::S_OUT : lvra_pkg::S_HY_W;
      end
      lvra_pkg::S_HY_W: begin
        if (stat.div_done) begin
          state_next = lvra_pkg::S_OUT;
        end
      end
      lvra_pkg::S_OUT: begin
        if (stat.out_free) begin
          state_next = lvra_pkg::S_IDLE;
        end
      end
      default: state_next = lvra_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = state != lvra_pkg::S_IDLE;
    case (state)
      lvra_pkg::S_IDLE: begin
        if (in_valid) begin
          case (func)
            lvra_pkg::FUNC_LOAD_RES:   cmd.wr_res    = 1'b1;
            lvra_pkg::FUNC_LOAD_IFACE: cmd.wr_if     = 1'b1;
            lvra_pkg::FUNC_EVAL:       cmd.load_eval = 1'b1;
            default:                   cmd.wr_res    = 1'b0;
          endcase
        end
      end
      lvra_pkg::S_READ: cmd.rd   = 1'b1;
      lvra_pkg::S_CLIP: cmd.clip = 1'b1;
      lvra_pkg::S_FRAC: begin
        cmd.div_sel   = lvra_pkg::DIV_FRAC;
        cmd.div_start = 1'b1;
      end
      lvra_pkg::S_FRAC_W: cmd.lat_frac = stat.div_done;
      lvra_pkg::S_CX: begin
        cmd.div_sel   = lvra_pkg::DIV_CX;
        cmd.div_start = !stat.rho_x_zero;
        cmd.set_zx    = stat.rho_x_zero;
      end
      lvra_pkg::S_CX_W: cmd.lat_cx = stat.div_done;
      lvra_pkg::S_CY: begin
        cmd.div_sel   = lvra_pkg::DIV_CY;
        cmd.div_start = !stat.rho_y_zero;
        cmd.set_zy    = stat.rho_y_zero;
      end
      lvra_pkg::S_CY_W: cmd.lat_cy     = stat.div_done;
      lvra_pkg::S_MZA:  cmd.mul_a      = 1'b1;
      lvra_pkg::S_MZB:  cmd.mul_b      = 1'b1;
      lvra_pkg::S_MZC:  cmd.acc_z      = 1'b1;
      lvra_pkg::S_NEXT: cmd.next_layer = 1'b1;
      lvra_pkg::S_HX: begin
        cmd.div_sel   = lvra_pkg::DIV_HX;
        cmd.div_start = !stat.hx_direct;
        cmd.lat_hx    = stat.hx_direct;
      end
      lvra_pkg::S_HX_W: cmd.lat_hx = stat.div_done;
      lvra_pkg::S_HY: begin
        cmd.div_sel   = lvra_pkg::DIV_HY;
        cmd.div_start = !stat.hy_direct;
        cmd.lat_hy    = stat.hy_direct;
      end
      lvra_pkg::S_HY_W: cmd.lat_hy   = stat.div_done;
      lvra_pkg::S_OUT:  cmd.out_load = stat.out_free;
      default:          cmd.rd       = 1'b0;
    endcase
  end

endmodule
